@@ rtl/pps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the priority process scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int SLOTS_DEF    = 16;
	localparam int PID_BITS_DEF = 16;

	localparam int PRIO_W     = 8;
	localparam int CREDIT_W   = 9;
	localparam int SLOT_OUT_W = 4;
	localparam int PID_OUT_W  = 16;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_CREATE = 2'd1,
		ACT_EXIT   = 2'd2
	} action_t;

endpackage
`default_nettype wire

@@ rtl/pps_slot_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pps_slot_mem
// Slot table memory: priority and pid per slot, one write and one read port,
// read data registered. Slot 0 reads as priority 1, pid 1 until written.
// ----------------------------------------------------------------------------
module pps_slot_mem #(
	parameter int SLOTS    = pps_pkg::SLOTS_DEF,
	parameter int PID_BITS = pps_pkg::PID_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          wr_en,
	input  wire  [$clog2(SLOTS)-1:0]     wr_idx,
	input  wire  [pps_pkg::PRIO_W-1:0]   wr_prio,
	input  wire  [PID_BITS-1:0]          wr_pid,
	input  wire                          rd_en,
	input  wire  [$clog2(SLOTS)-1:0]     rd_idx,
	output logic [pps_pkg::PRIO_W-1:0]   rd_prio,
	output logic [PID_BITS-1:0]          rd_pid
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int WORD_W = pps_pkg::PRIO_W + PID_BITS;

	logic [WORD_W-1:0] mem_q [SLOTS];
	logic [WORD_W-1:0] rd_word_s1;
	logic              rd_zero_s1;
	logic              w0_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= {wr_prio, wr_pid};
		end
		if (rd_en) begin
			rd_word_s1 <= mem_q[rd_idx];
		end
	end

	// slot 0 holds its reset contents until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q       <= 1'b0;
			rd_zero_s1 <= 1'b0;
		end else begin
			if (wr_en && wr_idx == IDX_W'(0)) begin
				w0_q <= 1'b1;
			end
			if (rd_en) begin
				rd_zero_s1 <= (rd_idx == IDX_W'(0));
			end
		end
	end

	always_comb begin
		if (rd_zero_s1 && !w0_q) begin
			rd_prio = pps_pkg::PRIO_W'(1);
			rd_pid  = PID_BITS'(1);
		end else begin
			rd_prio = rd_word_s1[WORD_W-1:PID_BITS];
			rd_pid  = rd_word_s1[PID_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/priority_process_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// priority_process_scheduler
// Process-slot table with a credit-counting priority scheduler.
// ----------------------------------------------------------------------------
// Use:
//  - Command port: raise start with action and priority_req while busy is
//    low; the word is taken at that edge and busy rises the next cycle.
//  - Actions: schedule tick, create process, exit running process and then
//    schedule. Any other code is ignored and answered at once.
//  - Result port: done is high for exactly one cycle with running_slot,
//    running_pid, switched, new_pid, new_slot and table_full valid. The
//    receiver cannot stall; the word is gone after that cycle.
//  - Scan: a tick or exit scans SLOTS+1 positions, one slot table read
//    a cycle through a memory with registered read data, and stops at the
//    first slot picked. A create walks the live bits from slot 0, one a
//    cycle, and stops at the first free slot.
//  - One word is worked on at a time; busy falls in the cycle done is high,
//    so the next word may be taken at the edge that ends it.
//  - Reset (arst_n low): slot 0 live with priority 1 and pid 1, all other
//    slots free, credit 0, next pid 2, slot 0 running. No clearing pass.
// ----------------------------------------------------------------------------
module priority_process_scheduler #(
	parameter int SLOTS    = pps_pkg::SLOTS_DEF,
	parameter int PID_BITS = pps_pkg::PID_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [1:0]                       action,
	input  wire  [pps_pkg::PRIO_W-1:0]       priority_req,
	output logic                             done,
	output logic [pps_pkg::SLOT_OUT_W-1:0]   running_slot,
	output logic [pps_pkg::PID_OUT_W-1:0]    running_pid,
	output logic                             switched,
	output logic [pps_pkg::PID_OUT_W-1:0]    new_pid,
	output logic [pps_pkg::SLOT_OUT_W-1:0]   new_slot,
	output logic                             table_full
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 2);
	localparam int SO_W  = pps_pkg::SLOT_OUT_W;
	localparam int PO_W  = pps_pkg::PID_OUT_W;
	localparam int CR_W  = pps_pkg::CREDIT_W;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SLOTS);
	localparam logic [SLOTS-1:0] LIVE_RST  = {{(SLOTS-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND
	} state_t;

	state_t                      state_q;
	logic [SLOTS-1:0]            live_q;       // per-slot live flags
	logic [IDX_W-1:0]            run_q;        // running slot
	logic [PID_BITS-1:0]         cur_pid_q;    // pid held by the running slot
	logic [CR_W-1:0]             credit_q;
	logic [PID_BITS-1:0]         next_pid_q;
	logic [pps_pkg::PRIO_W-1:0]  prio_q;       // priority of a pending create

	// scan: issue side and evaluate side (read data arrives in the next cycle)
	logic [IDX_W-1:0]            iss_q;
	logic [CNT_W-1:0]            iss_cnt_q;
	logic                        ev_v_s1;
	logic [IDX_W-1:0]            ev_k_s1;
	logic                        ev_last_s1;
	logic [IDX_W-1:0]            find_q;       // free-slot search pointer

	logic                        done_q;
	logic                        switched_q;
	logic                        full_q;
	logic [SO_W-1:0]             new_slot_q;
	logic [PO_W-1:0]             new_pid_q;

	// memory port signals
	logic                        rd_en;
	logic                        wr_en;
	logic [pps_pkg::PRIO_W-1:0]  rd_prio;
	logic [PID_BITS-1:0]         rd_pid;

	// evaluate stage
	logic                        ev_live;
	logic                        p_nz;
	logic                        take;
	logic                        clr;
	logic                        pick;
	logic [CR_W-1:0]             p_ext;
	logic [IDX_W-1:0]            iss_nx;
	logic                        word_end;     // result word goes out next cycle

	// output width adaptation
	logic [IDX_W+SO_W-1:0]       run_ext;
	logic [IDX_W+SO_W-1:0]       find_ext;
	logic [PID_BITS+PO_W-1:0]    cur_pid_ext;
	logic [PID_BITS+PO_W-1:0]    next_pid_ext;

	assign run_ext      = {{SO_W{1'b0}}, run_q};
	assign find_ext     = {{SO_W{1'b0}}, find_q};
	assign cur_pid_ext  = {{PO_W{1'b0}}, cur_pid_q};
	assign next_pid_ext = {{PO_W{1'b0}}, next_pid_q};

	// one read per cycle while positions of the SLOTS+1 walk remain
	assign rd_en  = (state_q == ST_SCAN) && (iss_cnt_q <= LAST_CNT);
	assign iss_nx = (iss_q == LAST_IDX) ? '0 : iss_q + IDX_W'(1);

	// create writes the first free slot found
	assign wr_en  = (state_q == ST_FIND) && !live_q[find_q];

	pps_slot_mem #(
		.SLOTS    (SLOTS),
		.PID_BITS (PID_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (find_q),
		.wr_prio (prio_q),
		.wr_pid  (next_pid_q),
		.rd_en   (rd_en),
		.rd_idx  (iss_q),
		.rd_prio (rd_prio),
		.rd_pid  (rd_pid)
	);

	// Credit rule: a nonzero priority at or above the credit wins and bumps
	// the credit; one just below it (p+1 == credit) clears the credit; a
	// zero priority wins only away from the starting slot.
	always_comb begin
		ev_live = live_q[ev_k_s1];
		p_ext   = {1'b0, rd_prio};
		p_nz    = (rd_prio != '0);
		take    = ev_live && p_nz && (p_ext >= credit_q);
		clr     = ev_live && p_nz && !take && ((p_ext + CR_W'(1)) == credit_q);
		pick    = take || (ev_live && !p_nz && (ev_k_s1 != run_q));
	end

	// answered at once for an unused code, else at the end of the scan or search
	assign word_end = ((state_q == ST_IDLE) && start &&
			!(action inside {pps_pkg::ACT_TICK, pps_pkg::ACT_CREATE, pps_pkg::ACT_EXIT}))
		|| ((state_q == ST_SCAN) && ev_v_s1 && (pick || ev_last_s1))
		|| ((state_q == ST_FIND) && (!live_q[find_q] || (find_q == LAST_IDX)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			live_q     <= LIVE_RST;
			run_q      <= '0;
			cur_pid_q  <= PID_BITS'(1);
			credit_q   <= '0;
			next_pid_q <= PID_BITS'(2);
			prio_q     <= '0;
			iss_q      <= '0;
			iss_cnt_q  <= '0;
			ev_v_s1    <= 1'b0;
			ev_k_s1    <= '0;
			ev_last_s1 <= 1'b0;
			find_q     <= '0;
			done_q     <= 1'b0;
			switched_q <= 1'b0;
			full_q     <= 1'b0;
			new_slot_q <= '0;
			new_pid_q  <= '0;
		end else begin
			done_q  <= word_end;
			ev_v_s1 <= rd_en;
			if (rd_en) begin
				ev_k_s1    <= iss_q;
				ev_last_s1 <= (iss_cnt_q == LAST_CNT);
				iss_q      <= iss_nx;
				iss_cnt_q  <= iss_cnt_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						switched_q <= 1'b0;
						full_q     <= 1'b0;
						new_slot_q <= '0;
						new_pid_q  <= '0;
						iss_q      <= run_q;
						iss_cnt_q  <= '0;
						find_q     <= '0;
						prio_q     <= priority_req;
						case (action)
							pps_pkg::ACT_TICK: begin
								state_q <= ST_SCAN;
							end
							pps_pkg::ACT_CREATE: begin
								state_q <= ST_FIND;
							end
							pps_pkg::ACT_EXIT: begin
								live_q[run_q] <= 1'b0;
								state_q       <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (ev_v_s1) begin
						if (take) begin
							credit_q <= credit_q + CR_W'(1);
						end else if (clr) begin
							credit_q <= '0;
						end
						if (pick) begin
							run_q      <= ev_k_s1;
							cur_pid_q  <= rd_pid;
							switched_q <= 1'b1;
						end
						if (pick || ev_last_s1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIND: begin
					if (!live_q[find_q]) begin
						live_q[find_q] <= 1'b1;
						new_slot_q     <= find_ext[SO_W-1:0];
						new_pid_q      <= next_pid_ext[PO_W-1:0];
						next_pid_q     <= next_pid_q + PID_BITS'(1);
						// a freed running slot can be reused at once
						if (find_q == run_q) begin
							cur_pid_q <= next_pid_q;
						end
						state_q <= ST_IDLE;
					end else if (find_q == LAST_IDX) begin
						full_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						find_q <= find_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign running_slot = run_ext[SO_W-1:0];
	assign running_pid  = cur_pid_ext[PO_W-1:0];
	assign switched     = switched_q;
	assign new_pid      = new_pid_q;
	assign new_slot     = new_slot_q;
	assign table_full   = full_q;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority process scheduler. Words go in on the
// start/busy command port and every result word on the done strobe is checked
// against a slot-table model kept in a small scoreboard class. A directed run
// covers reset behaviour, an empty and a full table and the unused action
// code. Randomised runs of ticks, creates and exits follow, with random
// sender gaps.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pps_pkg::*;

	localparam int         SLOTS        = SLOTS_DEF;
	localparam logic [1:0] ACT_UNUSED   = 2'd3;   // no action_t member: ignored by the block
	localparam int         RANDOM_WORDS = 1680;
	localparam int         WATCH_LIMIT  = 1000;   // idle cycles before the run is abandoned
	localparam int         SETTLE       = SLOTS + 8;

	// One result word, fields in port order.
	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic [PID_OUT_W-1:0]  pid;
		logic                  sw;
		logic [PID_OUT_W-1:0]  new_pid;
		logic [SLOT_OUT_W-1:0] new_slot;
		logic                  full;
	} sched_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the slot table, works out the word each event
	// should produce and holds those words until done brings them back.
	// ------------------------------------------------------------------------
	class sched_scoreboard;
		bit                 live[SLOTS];
		bit [PRIO_W-1:0]    prio[SLOTS];
		bit [PID_OUT_W-1:0] pid[SLOTS];
		int unsigned        run_idx;
		bit [CREDIT_W-1:0]  credit;
		bit [PID_OUT_W-1:0] next_pid;
		sched_result_t      due_results[$];
		int                 errors;

		function new();
			for (int s = 0; s < SLOTS; s++) begin
				live[s] = 1'b0;
				prio[s] = '0;
				pid[s]  = '0;
			end
			live[0]  = 1'b1;
			prio[0]  = 8'd1;
			pid[0]   = 16'd1;
			run_idx  = 0;
			credit   = '0;
			next_pid = 16'd2;
			errors   = 0;
		endfunction

		// Credit scan over SLOTS+1 positions from the running slot.
		function bit pick_slot();
			int unsigned       first;
			int unsigned       k;
			bit [CREDIT_W-1:0] p9;
			first = run_idx;
			for (int i = 0; i <= SLOTS; i++) begin
				k = (first + i) % SLOTS;
				if (!live[k])
					continue;
				p9 = {1'b0, prio[k]};
				if (p9 != 0 && p9 >= credit) begin
					credit  = credit + 1'b1;
					run_idx = k;
					return 1'b1;
				end
				if (p9 != 0 && p9 + 1'b1 == credit)
					credit = '0;
				if (p9 == 0 && k != first) begin
					run_idx = k;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			errors++;
			$display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		endtask

		// Accepted command word: update the table and queue the result.
		task note_word(logic [1:0] act, logic [PRIO_W-1:0] req_prio);
			sched_result_t r;
			int            k;
			bit            found;
			r     = '0;
			k     = 0;
			found = 1'b0;
			case (act)
				ACT_TICK: r.sw = pick_slot();
				ACT_CREATE: begin
					for (int s = 0; s < SLOTS; s++) begin
						if (!live[s] && !found) begin
							found = 1'b1;
							k     = s;
						end
					end
					if (found) begin
						live[k]    = 1'b1;
						prio[k]    = req_prio;
						pid[k]     = next_pid;
						r.new_pid  = next_pid;
						r.new_slot = k[SLOT_OUT_W-1:0];
						next_pid   = next_pid + 1'b1;
					end else begin
						r.full = 1'b1;
					end
				end
				ACT_EXIT: begin
					live[run_idx] = 1'b0;
					r.sw          = pick_slot();
				end
				default: ;
			endcase
			r.slot = run_idx[SLOT_OUT_W-1:0];
			r.pid  = pid[run_idx];
			due_results.push_back(r);
		endtask

		task check_word(sched_result_t got);
			sched_result_t want;
			if (due_results.size() == 0) begin
				report("result word with none expected, running_slot", got.slot, 0);
				return;
			end
			want = due_results.pop_front();
			if (got.slot !== want.slot)         report("running_slot", got.slot, want.slot);
			if (got.pid !== want.pid)           report("running_pid", got.pid, want.pid);
			if (got.sw !== want.sw)             report("switched", got.sw, want.sw);
			if (got.new_pid !== want.new_pid)   report("new_pid", got.new_pid, want.new_pid);
			if (got.new_slot !== want.new_slot) report("new_slot", got.new_slot, want.new_slot);
			if (got.full !== want.full)         report("table_full", got.full, want.full);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            action;
	logic [PRIO_W-1:0]     priority_req;
	logic                  done;
	logic [SLOT_OUT_W-1:0] running_slot;
	logic [PID_OUT_W-1:0]  running_pid;
	logic                  switched;
	logic [PID_OUT_W-1:0]  new_pid;
	logic [SLOT_OUT_W-1:0] new_slot;
	logic                  table_full;

	sched_scoreboard sb;
	int              idle_cycles = 0;

	priority_process_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.priority_req (priority_req),
		.done         (done),
		.running_slot (running_slot),
		.running_pid  (running_pid),
		.switched     (switched),
		.new_pid      (new_pid),
		.new_slot     (new_slot),
		.table_full   (table_full)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled on the rising edge. A command word is
	// noted before the result check so that an answer in the same edge would
	// still find its expectation queued.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(action, priority_req);
			if (done)
				sb.check_word(sched_result_t'({running_slot, running_pid, switched,
					new_pid, new_slot, table_full}));
			// watchdog counts edges at which neither port moved a word
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: a hung block ends the run here.
	initial begin
		wait (idle_cycles >= WATCH_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver. Called at a falling edge; holds the word until busy is low at a
	// falling edge, which means it is taken at the following rising edge.
	// With no gap, start stays high and the next word follows straight on.
	// ------------------------------------------------------------------------
	task send_word(input logic [1:0] act, input logic [PRIO_W-1:0] req_prio, input int gap);
		start        <= 1'b1;
		action       <= act;
		priority_req <= req_prio;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Sender holds off until every outstanding result word has come back.
	task wait_drained();
		start <= 1'b0;
		while (sb.due_results.size() != 0)
			@(negedge clk);
	endtask

	// Mostly back to back, often a short gap, now and then a long one.
	function int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Low priorities keep the credit near the priorities in play; the ends of
	// the range and random values are mixed in.
	function logic [PRIO_W-1:0] pick_prio();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		if (r < 40)
			return '1;
		if (r < 70)
			return $urandom_range(1, 4);
		return $urandom_range(0, 255);
	endfunction

	// mix 0: balanced, 1: filling the table, 2: draining it.
	function logic [1:0] pick_action(int unsigned mix);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mix)
			1: begin
				if (r < 20) return ACT_TICK;
				if (r < 80) return ACT_CREATE;
				if (r < 95) return ACT_EXIT;
			end
			2: begin
				if (r < 30) return ACT_TICK;
				if (r < 45) return ACT_CREATE;
				if (r < 95) return ACT_EXIT;
			end
			default: begin
				if (r < 40) return ACT_TICK;
				if (r < 65) return ACT_CREATE;
				if (r < 92) return ACT_EXIT;
			end
		endcase
		return ACT_UNUSED;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned mix;
		bit          quiet;
		int          seg_len;
		int          sent;
		logic [1:0]  act;

		sb           = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_TICK;
		priority_req = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: credit climbs on slot 0 then clears and wraps back round.
		repeat (3) send_word(ACT_TICK, '0, 0);
		// Exit of the only process: nothing to choose, freed slot stays running.
		send_word(ACT_EXIT, '0, 1);
		// Exit again on a slot already free, then a tick on an empty table.
		send_word(ACT_EXIT, '0, 0);
		send_word(ACT_TICK, '0, 2);
		send_word(ACT_UNUSED, 8'hAA, 0);
		// Fill every slot, then one more create on a full table.
		for (int s = 0; s <= SLOTS; s++) begin
			case (s % 4)
				0:       send_word(ACT_CREATE, 8'h00, 0);
				1:       send_word(ACT_CREATE, 8'hFF, 0);
				2:       send_word(ACT_CREATE, s[7:0], 0);
				default: send_word(ACT_CREATE, 8'hA5 ^ s[7:0], 0);
			endcase
		end
		send_word(ACT_UNUSED, 8'h55, 0);
		send_word(ACT_TICK, '0, 0);
		send_word(ACT_EXIT, '0, 0);
		wait_drained();

		// Random segments, each with its own action mix; some without gaps,
		// some followed by a full drain of the result queue.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			mix     = $urandom_range(0, 2);
			quiet   = ($urandom_range(0, 3) == 0);
			seg_len = $urandom_range(20, 120);
			for (int n = 0; n < seg_len && sent < RANDOM_WORDS; n++) begin
				act = pick_action(mix);
				send_word(act, pick_prio(), quiet ? 0 : pick_gap());
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
